// ----- design/pcm_pkg.sv -----
package pcm_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_SLOTS = 4;

    localparam logic [2:0] REG_PRIORITY_SRC0 = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_SRC0  = 3'd4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [7:0]  PRIORITY_RESET = 8'd0;

    localparam logic CMD_MESSAGE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [2:0] OWNER_IDLE = 3'd4;

    typedef struct packed {
        logic [REG_SLOTS-1:0][7:0]  priority_src;
        logic [REG_SLOTS-1:0][15:0] timeout_src;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [1:0]  source;
        logic        stamped;
        logic [63:0] payload;
    } item_t;

    typedef struct packed {
        logic        forward;
        logic [63:0] out_payload;
        logic        out_stamped;
        logic        owner_changed;
        logic [2:0]  owner;
        logic [3:0]  active_mask;
    } result_t;

endpackage

// ----- design/pcm_regs.sv -----
module pcm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcm_pkg::PADDR_W-1:0]   paddr,
    input  logic [pcm_pkg::PDATA_W-1:0]   pwdata,
    output logic [pcm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output pcm_pkg::cfg_t                 cfg
);

    logic [pcm_pkg::REG_SLOTS-1:0][7:0]  priority_reg;
    logic [pcm_pkg::REG_SLOTS-1:0][15:0] timeout_reg;
    logic [2:0]                          reg_index;
    logic                                wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pcm_pkg::REG_SLOTS; i++)
            begin
                priority_reg[i] <= pcm_pkg::PRIORITY_RESET;
                timeout_reg[i]  <= pcm_pkg::TIMEOUT_RESET;
            end
        end
        else if (wr_en)
        begin
            if (reg_index < pcm_pkg::REG_TIMEOUT_SRC0)
            begin
                priority_reg[reg_index[1:0]] <= pwdata[7:0];
            end
            else
            begin
                timeout_reg[reg_index[1:0]] <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (reg_index < pcm_pkg::REG_TIMEOUT_SRC0)
        begin
            prdata = pcm_pkg::PDATA_W'(priority_reg[reg_index[1:0]]);
        end
        else
        begin
            prdata = pcm_pkg::PDATA_W'(timeout_reg[reg_index[1:0]]);
        end
    end

    assign cfg.priority_src = priority_reg;
    assign cfg.timeout_src  = timeout_reg;

endmodule

// ----- design/pcm_core.sv -----
module pcm_core #(
    parameter int NUM_SOURCES = 4,
    parameter int TIMER_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pcm_pkg::cfg_t     cfg,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  pcm_pkg::item_t    item,
    output logic              res_valid,
    input  logic              res_ready,
    output pcm_pkg::result_t  result
);

    localparam logic [2:0] NUM_SRC = 3'(NUM_SOURCES);
    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    function automatic logic [TIMER_BITS-1:0] eff_timeout(input logic [15:0] t);
        logic [32:0] w;
        w = 33'(t);
        if (w == 33'd0)
        begin
            w = 33'd1;
        end
        if (w > TIMER_MAX)
        begin
            w = TIMER_MAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

    logic                                  in_valid_reg;
    pcm_pkg::item_t                        item_reg;
    logic                                  res_valid_reg;
    pcm_pkg::result_t                      res_reg;
    pcm_pkg::result_t                      res_next;
    logic                                  advance;

    logic [2:0]                            owner_reg, owner_next;
    logic [NUM_SOURCES-1:0][TIMER_BITS-1:0] cnt_reg, cnt_next;
    logic [NUM_SOURCES-1:0]                run_reg, run_next;
    logic [NUM_SOURCES-1:0]                act_reg, act_next;
    logic [TIMER_BITS:0]                   gcnt_reg, gcnt_next;
    logic                                  grun_reg, grun_next;

    logic [NUM_SOURCES-1:0][TIMER_BITS-1:0] eff;
    logic [TIMER_BITS-1:0]                 eff_max;
    logic [TIMER_BITS:0]                   global_period;
    logic                                  take;
    logic                                  go_idle;
    logic                                  changed;
    logic [TIMER_BITS-1:0]                 dec;
    logic [TIMER_BITS:0]                   gdec;

    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        eff_max = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            eff[i] = eff_timeout(cfg.timeout_src[i]);
            if (eff[i] > eff_max)
            begin
                eff_max = eff[i];
            end
        end
        global_period = {eff_max, 1'b0};
    end

    always_comb
    begin
        owner_next = owner_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        act_next   = act_reg;
        gcnt_next  = gcnt_reg;
        grun_next  = grun_reg;
        take       = 1'b0;
        go_idle    = 1'b0;
        changed    = 1'b0;
        dec        = '0;
        gdec       = '0;
        res_next.forward     = 1'b0;
        res_next.out_payload = '0;
        res_next.out_stamped = 1'b0;

        if (item_reg.command == pcm_pkg::CMD_MESSAGE)
        begin
            if ({1'b0, item_reg.source} < NUM_SRC)
            begin
                gcnt_next = global_period;
                grun_next = 1'b1;
                for (int i = 0; i < NUM_SOURCES; i++)
                begin
                    if (item_reg.source == 2'(i))
                    begin
                        cnt_next[i] = eff[i];
                        run_next[i] = 1'b1;
                        act_next[i] = 1'b1;
                    end
                end
                take = (owner_reg == pcm_pkg::OWNER_IDLE)
                    || (owner_reg == {1'b0, item_reg.source})
                    || (cfg.priority_src[item_reg.source]
                        > cfg.priority_src[owner_reg[1:0]]);
                if (take)
                begin
                    if (owner_reg != {1'b0, item_reg.source})
                    begin
                        owner_next = {1'b0, item_reg.source};
                        changed    = 1'b1;
                    end
                    res_next.forward     = 1'b1;
                    res_next.out_payload = item_reg.payload;
                    res_next.out_stamped = item_reg.stamped;
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                if (run_reg[i])
                begin
                    dec = (cnt_reg[i] != '0) ? cnt_reg[i] - 1'b1 : cnt_reg[i];
                    cnt_next[i] = dec;
                    if (dec == '0)
                    begin
                        run_next[i] = 1'b0;
                        act_next[i] = 1'b0;
                        if (owner_reg == 3'(i))
                        begin
                            go_idle = 1'b1;
                        end
                    end
                end
            end
            if (grun_reg)
            begin
                gdec = (gcnt_reg != '0) ? gcnt_reg - 1'b1 : gcnt_reg;
                gcnt_next = gdec;
                if (gdec == '0)
                begin
                    grun_next = 1'b0;
                    if (owner_reg != pcm_pkg::OWNER_IDLE)
                    begin
                        go_idle = 1'b1;
                    end
                end
            end
            if (go_idle)
            begin
                owner_next = pcm_pkg::OWNER_IDLE;
                changed    = 1'b1;
            end
        end

        res_next.owner_changed = changed;
        res_next.owner         = owner_next;
        res_next.active_mask   = 4'(act_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            owner_reg     <= pcm_pkg::OWNER_IDLE;
            cnt_reg       <= '0;
            run_reg       <= '0;
            act_reg       <= '0;
            gcnt_reg      <= '0;
            grun_reg      <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                in_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                owner_reg     <= owner_next;
                cnt_reg       <= cnt_next;
                run_reg       <= run_next;
                act_reg       <= act_next;
                gcnt_reg      <= gcnt_next;
                grun_reg      <= grun_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- design/priority_command_mux_timeout.sv -----
// Priority multiplexer for command words from several sources, with timeouts.
// Items enter on the cmd channel (cmd_valid/cmd_ready): a message from a source
// or a time tick. Every item gives exactly one result transfer on the res channel
// (res_valid/res_ready): forwarded payload, current owner and active sources.
// Priorities and timeouts are set through the APB port before traffic starts.
// An accepted item waits in the input register while the arbitration and timer
// logic works on it, and the result register then loads the outcome. Throughput
// is one item per cycle while the receiver does not stall; the owner and timer
// registers are updated in the same cycle that the result register loads, so the
// next item sees them immediately.
// When the receiver stalls, the result register holds its transfer and the input
// register takes one more item; after that cmd_ready drops until res_ready returns.
// Reset leaves the output idle (owner 4), all timers stopped, all sources
// inactive, priorities at 0 and timeouts at 100 ticks.
module priority_command_mux_timeout #(
    parameter int NUM_SOURCES = 4,
    parameter int TIMER_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcm_pkg::PADDR_W-1:0] paddr,
    input  logic [pcm_pkg::PDATA_W-1:0] pwdata,
    output logic [pcm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic                        command,
    input  logic [1:0]                  source,
    input  logic                        stamped,
    input  logic [63:0]                 payload,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic                        forward,
    output logic [63:0]                 out_payload,
    output logic                        out_stamped,
    output logic                        owner_changed,
    output logic [2:0]                  owner,
    output logic [3:0]                  active_mask
);

    pcm_pkg::cfg_t    cfg;
    pcm_pkg::item_t   item;
    pcm_pkg::result_t result;

    assign item.command = command;
    assign item.source  = source;
    assign item.stamped = stamped;
    assign item.payload = payload;

    pcm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcm_core #(
        .NUM_SOURCES (NUM_SOURCES),
        .TIMER_BITS  (TIMER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    assign forward       = result.forward;
    assign out_payload   = result.out_payload;
    assign out_stamped   = result.out_stamped;
    assign owner_changed = result.owner_changed;
    assign owner         = result.owner;
    assign active_mask   = result.active_mask;

endmodule

// ----- design/pcm_checker.sv -----
module pcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        forward,
    input logic [63:0] out_payload,
    input logic        out_stamped,
    input logic [2:0]  owner,
    input logic [3:0]  active_mask
);

    // A forwarded message always leaves an owner in place.
    a_forward_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && forward |-> owner != pcm_pkg::OWNER_IDLE)
        else $error("forwarded transfer without an owner");

    a_quiet_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !forward |-> out_payload == 64'd0 && !out_stamped)
        else $error("payload fields set on a transfer that does not forward");

    // The owner is always a source that has not timed out.
    a_owner_active: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && owner != pcm_pkg::OWNER_IDLE |-> active_mask[owner[1:0]])
        else $error("owner is not marked active");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_payload) && $stable(owner))
        else $error("stalled result transfer changed");

endmodule

bind priority_command_mux_timeout pcm_checker u_pcm_checker (.*);
